/* src/rgba_to_4x4_tile_swizzle_assert.svh */
// Assertion macros used by the checker of the tile swizzle block.
`ifndef RGBA_TO_4X4_TILE_SWIZZLE_ASSERT_SVH
`define RGBA_TO_4X4_TILE_SWIZZLE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RTTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tile swizzle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RTTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tile swizzle check failed");

`endif

/* src/rtts_pkg.sv */
// Shared constants and types of the RGBA to 4x4 tile swizzle block.
package rtts_pkg;

  localparam int COUNT_W     = 10;
  localparam int SIZE_W      = 11;
  localparam int COL_EXT_W   = 13;
  localparam int PIXEL_W     = 32;
  localparam int BYTE_W      = 8;
  localparam int PAIR_W      = 5;
  localparam int CFG_IDX_W   = 2;

  localparam int MAX_WIDTH_DEFAULT = 1024;

  localparam logic [PAIR_W-1:0] LAST_PAIR = 5'd31;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USED_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] ROW_PITCH_RESET    = 11'd640;
  localparam logic [SIZE_W-1:0] USED_WIDTH_RESET   = 11'd640;
  localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RESET = 11'd32;

  typedef struct packed {
    logic              accept;
    logic              rd_en;
    logic [PAIR_W-1:0] pair;
  } cmd_t;

endpackage

/* src/rtts_if.sv */
// Handshake channels of the tile swizzle block: incoming pixels and outgoing byte pairs.
interface rtts_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [rtts_pkg::BYTE_W-1:0] red;
  logic [rtts_pkg::BYTE_W-1:0] green;
  logic [rtts_pkg::BYTE_W-1:0] blue;
  logic [rtts_pkg::BYTE_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface rtts_pair_if;
  logic                       valid;
  logic                       ready;
  logic [rtts_pkg::BYTE_W-1:0] first_byte;
  logic [rtts_pkg::BYTE_W-1:0] second_byte;
  logic                       tile_done;
  logic                       frame_done;

  modport source (output valid, first_byte, second_byte, tile_done, frame_done, input ready);
  modport sink (input valid, first_byte, second_byte, tile_done, frame_done, output ready);
endinterface

/* src/rtts_ctrl.sv */
// Controller: pixel intake and sequencing of the 32 store reads of a tile.
module rtts_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                tile_hit,
  output rtts_pkg::cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EMIT  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                  state;
  logic [1:0]                  state_next;
  logic [rtts_pkg::PAIR_W-1:0] issue;
  logic [rtts_pkg::PAIR_W-1:0] issue_next;
  logic                        advance;

  assign advance = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    issue_next = issue;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.pair   = issue;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && tile_hit) begin
          state_next = ST_EMIT;
          issue_next = '0;
        end
      end
      ST_EMIT: begin
        // The read data register doubles as the output stage, so a read is
        // issued only when the pair it holds has been taken.
        if (advance) begin
          cmd.rd_en  = 1'b1;
          issue_next = issue + 1'b1;
          if (issue == rtts_pkg::LAST_PAIR) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_valid && out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      issue <= issue_next;
      if (cmd.rd_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/rtts_datapath.sv */
// Datapath: configuration registers, row and column counters, band store and pair output stage.
module rtts_datapath #(
  parameter int MAX_WIDTH = rtts_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rtts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtts_pkg::SIZE_W-1:0]    cfg_data,
  input  logic [rtts_pkg::BYTE_W-1:0]    red,
  input  logic [rtts_pkg::BYTE_W-1:0]    green,
  input  logic [rtts_pkg::BYTE_W-1:0]    blue,
  input  logic [rtts_pkg::BYTE_W-1:0]    alpha,
  input  rtts_pkg::cmd_t                 cmd,
  output logic                           tile_hit,
  output logic [rtts_pkg::BYTE_W-1:0]    first_byte,
  output logic [rtts_pkg::BYTE_W-1:0]    second_byte,
  output logic                           tile_done,
  output logic                           frame_done
);

  localparam int CW    = (MAX_WIDTH > 4) ? $clog2(MAX_WIDTH) : 2;
  localparam int AW    = CW + 2;
  localparam int DEPTH = 4 << CW;
  localparam int SW    = rtts_pkg::SIZE_W;
  localparam int XW    = rtts_pkg::COL_EXT_W;
  localparam logic [SW-1:0] COUNT_LIMIT = SW'(1024);

  function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v);
    logic [SW-1:0] r;
    r = v;
    if (v == '0) begin
      r = SW'(1);
    end else if (v > COUNT_LIMIT) begin
      r = COUNT_LIMIT;
    end
    return r;
  endfunction

  logic [SW-1:0]                     row_pitch;
  logic [SW-1:0]                     used_width;
  logic [SW-1:0]                     image_height;
  logic [rtts_pkg::COUNT_W-1:0]      column_count;
  logic [rtts_pkg::COUNT_W-1:0]      row_count;
  logic [rtts_pkg::COUNT_W-1:0]      base_col;
  logic                              last_tile;
  logic [rtts_pkg::PIXEL_W-1:0]      band_store [0:DEPTH-1];
  logic [rtts_pkg::PIXEL_W-1:0]      rdata;
  logic [rtts_pkg::PAIR_W-1:0]       out_pair;

  logic [SW-1:0] pitch;
  logic [SW-1:0] height;
  logic [SW-1:0] whole_rows;
  logic [XW-1:0] width_min;
  logic [XW-1:0] width;
  logic [XW-1:0] col_ext;
  logic [SW-1:0] col_inc;
  logic [SW-1:0] row_inc;
  logic          col_in_range;
  logic          last_now;
  logic [XW-1:0] rd_col;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  always_comb begin
    pitch      = clamp_size(row_pitch);
    height     = clamp_size(image_height);
    whole_rows = {height[SW-1:2], 2'b00};
    width_min  = XW'(used_width);
    if (XW'(pitch) < width_min) begin
      width_min = XW'(pitch);
    end
    if (XW'(MAX_WIDTH) < width_min) begin
      width_min = XW'(MAX_WIDTH);
    end
    width        = {width_min[XW-1:2], 2'b00};
    col_ext      = XW'(column_count);
    col_inc      = SW'(column_count) + SW'(1);
    row_inc      = SW'(row_count) + SW'(1);
    col_in_range = col_ext < width;
    tile_hit     = col_in_range && (column_count[1:0] == 2'b11) &&
                   (row_count[1:0] == 2'b11) && (SW'(row_count) < whole_rows);
    last_now     = (col_ext + XW'(1) == width) && (row_inc == whole_rows);
    waddr        = {row_count[1:0], col_ext[CW-1:0]};
    rd_col       = XW'(base_col) + XW'(cmd.pair[1:0]);
    raddr        = {cmd.pair[3:2], rd_col[CW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pitch    <= rtts_pkg::ROW_PITCH_RESET;
      used_width   <= rtts_pkg::USED_WIDTH_RESET;
      image_height <= rtts_pkg::IMAGE_HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rtts_pkg::REG_ROW_PITCH:    row_pitch    <= cfg_data;
        rtts_pkg::REG_USED_WIDTH:   used_width   <= cfg_data;
        rtts_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A column counter left beyond a shrunken pitch wraps on the next pixel, and a row counter
  // beyond a shrunken height at the next row end, as the compares use greater-or-equal.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.accept) begin
      if (col_inc >= pitch) begin
        column_count <= '0;
        if (row_inc >= height) begin
          row_count <= '0;
        end else begin
          row_count <= row_inc[rtts_pkg::COUNT_W-1:0];
        end
      end else begin
        column_count <= col_inc[rtts_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && tile_hit) begin
      base_col  <= column_count - rtts_pkg::COUNT_W'(3);
      last_tile <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && col_in_range) begin
      band_store[waddr] <= {alpha, blue, green, red};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata    <= band_store[raddr];
      out_pair <= cmd.pair;
    end
  end

  // The first half of a tile carries alpha and red, the second green and blue.
  always_comb begin
    if (out_pair[4]) begin
      first_byte  = rdata[15:8];
      second_byte = rdata[23:16];
    end else begin
      first_byte  = rdata[31:24];
      second_byte = rdata[7:0];
    end
    tile_done  = out_pair == rtts_pkg::LAST_PAIR;
    frame_done = tile_done && last_tile;
  end

endmodule

/* src/rgba_to_4x4_tile_swizzle.sv */
// A pixel that does not finish a tile is accepted as soon as it is valid.
// The pixel that finishes a tile starts 32 pair beats; the first is valid once the controller
// has entered its emit state and read the first pair into the read data register; the rest
// follow one per cycle while the sink is ready, each read from the band store's single read
// port. Input is held off until the last beat is taken.
// Reset clears the counters and restores the size registers; the band store is not cleared.
module rgba_to_4x4_tile_swizzle #(
  parameter int MAX_WIDTH = rtts_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rtts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtts_pkg::SIZE_W-1:0]    cfg_data,
  rtts_pixel_if.sink                     pixel,
  rtts_pair_if.source                    pair
);

  rtts_pkg::cmd_t cmd;
  logic           tile_hit;

  rtts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .out_valid (pair.valid),
    .out_ready (pair.ready),
    .tile_hit  (tile_hit),
    .cmd       (cmd)
  );

  rtts_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .red         (pixel.red),
    .green       (pixel.green),
    .blue        (pixel.blue),
    .alpha       (pixel.alpha),
    .cmd         (cmd),
    .tile_hit    (tile_hit),
    .first_byte  (pair.first_byte),
    .second_byte (pair.second_byte),
    .tile_done   (pair.tile_done),
    .frame_done  (pair.frame_done)
  );

endmodule

/* src/rtts_checker.sv */
// Port-level checker of the tile swizzle block and its bind to the top level.
`include "rgba_to_4x4_tile_swizzle_assert.svh"

module rtts_checker (
  input logic         clk,
  input logic         rst,
  rtts_pixel_if.sink  pixel,
  rtts_pair_if.source pair
);

  // A stalled pair beat keeps its payload.
  `RTTS_ASSERT_NEXT(a_pair_hold, pair.valid && !pair.ready, pair.valid && $stable(pair.first_byte) && $stable(pair.second_byte) && $stable(pair.tile_done) && $stable(pair.frame_done))

  // No pixel is taken while a tile is being sent.
  `RTTS_ASSERT_NOW(a_no_intake_during_tile, pair.valid, !pixel.ready)

  // The frame end only ever marks the last beat of a tile.
  `RTTS_ASSERT_NOW(a_frame_on_tile_end, pair.valid && pair.frame_done, pair.tile_done)

  // Once the last beat of a tile is taken, the output goes quiet.
  `RTTS_ASSERT_NEXT(a_quiet_after_tile, pair.valid && pair.ready && pair.tile_done, !pair.valid)

endmodule

bind rgba_to_4x4_tile_swizzle rtts_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .pixel (pixel),
  .pair  (pair)
);
